>>> design/rvob_pkg.sv
// ----------------------------------------------------------------------------
// rvob_pkg: shared types and constants for the ray versus oriented boxes block
// Field widths, derived datapath widths, queue item and box entry records.
// ----------------------------------------------------------------------------
`default_nettype none

package rvob_pkg;

    // default table depth for the top level
    localparam int MAX_BOXES_DEF = 64;
    // trig values are Q15: scale is 2**TRIG_SHIFT
    localparam int TRIG_SHIFT = 15;
    // queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // field widths
    localparam int CNT_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int PT_W    = 32;
    localparam int HALF_W  = 31;
    localparam int TRIG_W  = 17;
    localparam int REACH_W = 31;

    // datapath widths
    localparam int EX_W    = PT_W + 1;                    // origin minus center
    localparam int PROD_W  = EX_W + TRIG_W;               // offset times trig
    localparam int ROT_W   = PROD_W + 1;                  // sum of two products
    localparam int LOC_W   = ROT_W - TRIG_SHIFT;          // local origin
    localparam int DPROD_W = 2 * TRIG_W;                  // direction times trig
    localparam int DSUM_W  = DPROD_W + 1;
    localparam int DIR_W   = DSUM_W - TRIG_SHIFT;         // local direction
    localparam int SPAN_W  = LOC_W + 1;                   // bound minus origin
    localparam int NUM_W   = SPAN_W + TRIG_SHIFT;         // scaled numerator

    typedef enum logic {
        ITEM_WRITE = 1'b0,
        ITEM_CAST  = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t                 kind;
        logic [SLOT_W-1:0]          slot;
        logic signed [PT_W-1:0]     point_x;
        logic signed [PT_W-1:0]     point_y;
        logic [HALF_W-1:0]          half_w;
        logic [HALF_W-1:0]          half_h;
        logic signed [TRIG_W-1:0]   rot_cosine;
        logic signed [TRIG_W-1:0]   rot_sine;
        logic signed [TRIG_W-1:0]   ray_dir_x;
        logic signed [TRIG_W-1:0]   ray_dir_y;
        logic [REACH_W-1:0]         reach;
        logic [CNT_W-1:0]           count;
    } queue_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic signed [PT_W-1:0]   center_x;
        logic signed [PT_W-1:0]   center_y;
        logic [HALF_W-1:0]        half_w;
        logic [HALF_W-1:0]        half_h;
        logic signed [TRIG_W-1:0] cosine;
        logic signed [TRIG_W-1:0] sine;
    } box_entry_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_READ,
        B_MUL,
        B_SUM,
        B_PREP,
        B_DIV,
        B_EVAL_X,
        B_EVAL_Y,
        B_FINISH
    } back_state_t;

endpackage

`default_nettype wire

>>> design/ray_vs_oriented_boxes.sv
// ----------------------------------------------------------------------------
// ray_vs_oriented_boxes: nearest ray hit against a table of rotated boxes
// Front classifies items, a short queue decouples it from the cast engine.
// ----------------------------------------------------------------------------
// A box write is done in the engine's idle state. A cast walks the first
// active_boxes table entries, one at a time: each box runs four bit-serial
// dividers in parallel for its slab distances, around a table read, a
// multiply stage, a rotation sum stage, a divider start stage and two slab
// compare stages. A cast with no active boxes returns reach without reading
// the table. Up to two items queue ahead of the engine, and a finished
// result waits in the output register without blocking the next item.
// Table entries read by a cast must have been written first.
`default_nettype none

module ray_vs_oriented_boxes import rvob_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_cmd,
    input  wire logic [SLOT_W-1:0]        s_box_slot,
    input  wire logic signed [PT_W-1:0]   s_point_x,
    input  wire logic signed [PT_W-1:0]   s_point_y,
    input  wire logic [HALF_W-1:0]        s_half_w,
    input  wire logic [HALF_W-1:0]        s_half_h,
    input  wire logic signed [TRIG_W-1:0] s_rot_cosine,
    input  wire logic signed [TRIG_W-1:0] s_rot_sine,
    input  wire logic signed [TRIG_W-1:0] s_ray_dir_x,
    input  wire logic signed [TRIG_W-1:0] s_ray_dir_y,
    input  wire logic [REACH_W-1:0]       s_reach,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [REACH_W-1:0]            m_hit_distance,
    output logic                          m_any_hit,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CNT_W-1:0]         cfg_data
);

    queue_status_t q_status;
    queue_item_t   push_item, pop_item;
    logic          push, pop;

    rvob_front #(.MAX_BOXES(MAX_BOXES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_box_slot(s_box_slot), .s_point_x(s_point_x), .s_point_y(s_point_y),
        .s_half_w(s_half_w), .s_half_h(s_half_h),
        .s_rot_cosine(s_rot_cosine), .s_rot_sine(s_rot_sine),
        .s_ray_dir_x(s_ray_dir_x), .s_ray_dir_y(s_ray_dir_y), .s_reach(s_reach),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .q_status(q_status), .push(push), .push_item(push_item)
    );

    rvob_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_item(push_item),
        .pop(pop), .pop_item(pop_item), .status(q_status)
    );

    rvob_back #(.MAX_BOXES(MAX_BOXES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_item(pop_item), .q_status(q_status), .q_pop(pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit_distance(m_hit_distance), .m_any_hit(m_any_hit)
    );

endmodule

`default_nettype wire

>>> design/rvob_queue.sv
// ----------------------------------------------------------------------------
// rvob_queue: short item queue between front and back
// Holds classified items so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module rvob_queue import rvob_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire queue_item_t   push_item,
    input  wire logic          pop,
    output queue_item_t        pop_item,
    output queue_status_t      status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    queue_item_t           slots [DEPTH];
    logic [AW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic                  do_push, do_pop;

    assign status.full  = (fill_reg == CW'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_item     = slots[rd_ptr_reg];

    // advance pointers with wrap
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // store the pushed item
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> design/rvob_front.sv
// ----------------------------------------------------------------------------
// rvob_front: input acceptance and classification
// Holds the active box count, drops writes beyond the table, queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module rvob_front import rvob_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_cmd,
    input  wire logic [SLOT_W-1:0]      s_box_slot,
    input  wire logic signed [PT_W-1:0] s_point_x,
    input  wire logic signed [PT_W-1:0] s_point_y,
    input  wire logic [HALF_W-1:0]      s_half_w,
    input  wire logic [HALF_W-1:0]      s_half_h,
    input  wire logic signed [TRIG_W-1:0] s_rot_cosine,
    input  wire logic signed [TRIG_W-1:0] s_rot_sine,
    input  wire logic signed [TRIG_W-1:0] s_ray_dir_x,
    input  wire logic signed [TRIG_W-1:0] s_ray_dir_y,
    input  wire logic [REACH_W-1:0]     s_reach,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CNT_W-1:0]       cfg_data,
    input  wire queue_status_t          q_status,
    output logic                        push,
    output queue_item_t                 push_item
);

    logic [CNT_W-1:0] active_boxes_reg;
    logic [31:0]      count_sat;
    logic             slot_ok;
    item_kind_t       kind;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_status.full;
    assign kind      = item_kind_t'(s_cmd);

    // saturate the box count to the table depth
    assign count_sat = (32'(active_boxes_reg) > 32'(MAX_BOXES)) ? 32'(MAX_BOXES)
                                                                : 32'(active_boxes_reg);
    assign slot_ok   = (32'(s_box_slot) < 32'(MAX_BOXES));

    // drop writes to slots beyond the table
    assign push = s_valid && s_ready && ((kind == ITEM_CAST) || slot_ok);

    always_comb begin
        push_item.kind       = kind;
        push_item.slot       = s_box_slot;
        push_item.point_x    = s_point_x;
        push_item.point_y    = s_point_y;
        push_item.half_w     = s_half_w;
        push_item.half_h     = s_half_h;
        push_item.rot_cosine = s_rot_cosine;
        push_item.rot_sine   = s_rot_sine;
        push_item.ray_dir_x  = s_ray_dir_x;
        push_item.ray_dir_y  = s_ray_dir_y;
        push_item.reach      = s_reach;
        push_item.count      = count_sat[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_boxes_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            active_boxes_reg <= cfg_data;
        end
    end

endmodule

`default_nettype wire

>>> design/rvob_div.sv
// ----------------------------------------------------------------------------
// rvob_div: bit-serial signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module rvob_div import rvob_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] dividend,
    input  wire logic signed [DIR_W-1:0] divisor,
    output logic                         busy,
    output logic signed [NUM_W-1:0]      quotient
);

    localparam int SC_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic [SC_W-1:0]   step_reg;
    logic [DIR_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DIR_W-1:0]  dmag_reg;
    logic              neg_reg;
    logic [DIR_W:0]    trial;
    logic [DIR_W:0]    diff;
    logic              fits;

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    // one restoring step
    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, dmag_reg};
        fits     = (trial >= {1'b0, dmag_reg});
        rem_next = fits ? diff[DIR_W-1:0] : trial[DIR_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= SC_W'(NUM_W);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == SC_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // load magnitudes, then shift in quotient bits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quo_reg  <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
            dmag_reg <= divisor[DIR_W-1] ? DIR_W'(-divisor) : DIR_W'(divisor);
            neg_reg  <= dividend[NUM_W-1] ^ divisor[DIR_W-1];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

`default_nettype wire

>>> design/rvob_back.sv
// ----------------------------------------------------------------------------
// rvob_back: box table and cast engine
// Writes table entries, walks the active boxes for a cast, keeps the nearest hit.
// ----------------------------------------------------------------------------
`default_nettype none

module rvob_back import rvob_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire queue_item_t         q_item,
    input  wire queue_status_t       q_status,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [REACH_W-1:0]       m_hit_distance,
    output logic                     m_any_hit
);

    localparam int BOX_AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int BOX_CW = $clog2(MAX_BOXES + 1);
    localparam logic signed [ROT_W-1:0]  ROT_BIAS  = ROT_W'((1 << TRIG_SHIFT) - 1);
    localparam logic signed [DSUM_W-1:0] DSUM_BIAS = DSUM_W'((1 << TRIG_SHIFT) - 1);

    back_state_t state_reg, state_next;

    box_entry_t  table_mem [MAX_BOXES];
    box_entry_t  rd_entry_reg;
    box_entry_t  wr_entry;
    logic        mem_we;
    logic [31:0] wr_addr32;
    logic [BOX_AW-1:0] wr_addr;

    // cast context
    logic signed [PT_W-1:0]   px_reg, py_reg;
    logic signed [TRIG_W-1:0] rx_reg, ry_reg;
    logic [REACH_W-1:0]       reach_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [BOX_CW-1:0]        k_reg;
    logic [REACH_W-1:0]       best_reg;
    logic [HALF_W-1:0]        hw_reg, hh_reg;

    // products and local frame
    logic signed [PROD_W-1:0]  p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [DPROD_W-1:0] d_xc_reg, d_ys_reg, d_xs_reg, d_yc_reg;
    logic signed [EX_W-1:0]    ex, ey;
    logic signed [ROT_W-1:0]   ox_sum, oy_sum;
    logic signed [DSUM_W-1:0]  dx_sum, dy_sum;
    logic signed [ROT_W-1:0]   ox_full, oy_full;
    logic signed [DSUM_W-1:0]  dx_full, dy_full;
    logic signed [LOC_W-1:0]   ox_reg, oy_reg;
    logic signed [DIR_W-1:0]   dx_reg, dy_reg;

    // slab math
    logic signed [SPAN_W-1:0] hx_s, hy_s, ox_e, oy_e;
    logic signed [SPAN_W-1:0] sx_lo, sx_hi, sy_lo, sy_hi;
    logic signed [DIR_W-1:0]  dvx, dvy;
    logic                     div_start;
    logic                     busy_x1, busy_x2, busy_y1, busy_y2;
    logic signed [NUM_W-1:0]  qx1, qx2, qy1, qy2;
    logic signed [NUM_W-1:0]  reach_s;
    logic signed [NUM_W-1:0]  lo_x, hi_x, lo_y, hi_y;
    logic signed [NUM_W-1:0]  tmin_x, tmax_x, tmin_y, tmax_y;
    logic signed [NUM_W-1:0]  tmin_reg, tmax_reg;
    logic                     miss_x, miss_y, miss_reg;
    logic [REACH_W-1:0]       h_dist;
    logic                     last_box;
    logic                     out_free;
    logic                     load_out;
    logic                     m_valid_reg;
    logic [REACH_W-1:0]       m_dist_reg;
    logic                     m_hit_reg;

    assign m_valid        = m_valid_reg;
    assign m_hit_distance = m_dist_reg;
    assign m_any_hit      = m_hit_reg;
    assign out_free       = !m_valid_reg || m_ready;
    assign last_box       = (32'(k_reg) + 32'd1 >= 32'(n_reg));

    // table write from a queued item
    assign wr_addr32 = 32'(q_item.slot);
    assign wr_addr   = wr_addr32[BOX_AW-1:0];
    always_comb begin
        wr_entry.center_x = q_item.point_x;
        wr_entry.center_y = q_item.point_y;
        wr_entry.half_w   = q_item.half_w;
        wr_entry.half_h   = q_item.half_h;
        wr_entry.cosine   = q_item.rot_cosine;
        wr_entry.sine     = q_item.rot_sine;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= table_mem[k_reg[BOX_AW-1:0]];
    end

    // next state and control
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_status.empty) begin
                    q_pop = 1'b1;
                    if (q_item.kind == ITEM_WRITE) begin
                        mem_we = 1'b1;
                    end else if (q_item.count == '0) begin
                        state_next = B_FINISH;
                    end else begin
                        state_next = B_READ;
                    end
                end
            end
            B_READ:   state_next = B_MUL;
            B_MUL:    state_next = B_SUM;
            B_SUM:    state_next = B_PREP;
            B_PREP: begin
                div_start  = 1'b1;
                state_next = B_DIV;
            end
            B_DIV: begin
                if (!(busy_x1 || busy_x2 || busy_y1 || busy_y2)) begin
                    state_next = B_EVAL_X;
                end
            end
            B_EVAL_X: state_next = B_EVAL_Y;
            B_EVAL_Y: state_next = last_box ? B_FINISH : B_READ;
            B_FINISH: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // offsets, rotation sums and truncating scale
    assign ex = EX_W'(px_reg) - EX_W'(rd_entry_reg.center_x);
    assign ey = EX_W'(py_reg) - EX_W'(rd_entry_reg.center_y);

    always_comb begin
        ox_sum  = ROT_W'(p_xc_reg) + ROT_W'(p_ys_reg);
        oy_sum  = ROT_W'(p_yc_reg) - ROT_W'(p_xs_reg);
        dx_sum  = DSUM_W'(d_xc_reg) + DSUM_W'(d_ys_reg);
        dy_sum  = DSUM_W'(d_yc_reg) - DSUM_W'(d_xs_reg);
        ox_full = (ox_sum + (ox_sum[ROT_W-1] ? ROT_BIAS : '0)) >>> TRIG_SHIFT;
        oy_full = (oy_sum + (oy_sum[ROT_W-1] ? ROT_BIAS : '0)) >>> TRIG_SHIFT;
        dx_full = (dx_sum + (dx_sum[DSUM_W-1] ? DSUM_BIAS : '0)) >>> TRIG_SHIFT;
        dy_full = (dy_sum + (dy_sum[DSUM_W-1] ? DSUM_BIAS : '0)) >>> TRIG_SHIFT;
    end

    // slab numerators and divisors
    always_comb begin
        hx_s  = SPAN_W'({1'b0, hw_reg});
        hy_s  = SPAN_W'({1'b0, hh_reg});
        ox_e  = SPAN_W'(ox_reg);
        oy_e  = SPAN_W'(oy_reg);
        sx_lo = -hx_s - ox_e;
        sx_hi = hx_s - ox_e;
        sy_lo = -hy_s - oy_e;
        sy_hi = hy_s - oy_e;
        dvx   = (dx_reg == '0) ? DIR_W'(1) : dx_reg;
        dvy   = (dy_reg == '0) ? DIR_W'(1) : dy_reg;
    end

    rvob_div u_div_x1 (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend({sx_lo, {TRIG_SHIFT{1'b0}}}), .divisor(dvx),
        .busy(busy_x1), .quotient(qx1)
    );
    rvob_div u_div_x2 (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend({sx_hi, {TRIG_SHIFT{1'b0}}}), .divisor(dvx),
        .busy(busy_x2), .quotient(qx2)
    );
    rvob_div u_div_y1 (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend({sy_lo, {TRIG_SHIFT{1'b0}}}), .divisor(dvy),
        .busy(busy_y1), .quotient(qy1)
    );
    rvob_div u_div_y2 (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend({sy_hi, {TRIG_SHIFT{1'b0}}}), .divisor(dvy),
        .busy(busy_y2), .quotient(qy2)
    );

    // local x slab, starting from zero and reach
    assign reach_s = NUM_W'({1'b0, reach_reg});
    always_comb begin
        lo_x   = (qx1 < qx2) ? qx1 : qx2;
        hi_x   = (qx1 < qx2) ? qx2 : qx1;
        tmin_x = '0;
        tmax_x = reach_s;
        miss_x = 1'b0;
        if (dx_reg == '0 && dy_reg == '0) begin
            miss_x = 1'b1;
        end else if (dx_reg == '0) begin
            miss_x = (ox_e < -hx_s) || (ox_e > hx_s);
        end else begin
            tmin_x = (lo_x > tmin_x) ? lo_x : tmin_x;
            tmax_x = (hi_x < tmax_x) ? hi_x : tmax_x;
            miss_x = (tmin_x > tmax_x);
        end
    end

    // local y slab, then the box distance
    always_comb begin
        lo_y   = (qy1 < qy2) ? qy1 : qy2;
        hi_y   = (qy1 < qy2) ? qy2 : qy1;
        tmin_y = tmin_reg;
        tmax_y = tmax_reg;
        miss_y = miss_reg;
        if (!miss_reg) begin
            if (dy_reg == '0) begin
                miss_y = (oy_e < -hy_s) || (oy_e > hy_s);
            end else begin
                tmin_y = (lo_y > tmin_y) ? lo_y : tmin_y;
                tmax_y = (hi_y < tmax_y) ? hi_y : tmax_y;
                miss_y = (tmin_y > tmax_y);
            end
        end
        h_dist = miss_y ? reach_reg : tmin_y[REACH_W-1:0];
    end

    // datapath registers by step
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                px_reg    <= q_item.point_x;
                py_reg    <= q_item.point_y;
                rx_reg    <= q_item.ray_dir_x;
                ry_reg    <= q_item.ray_dir_y;
                reach_reg <= q_item.reach;
                n_reg     <= q_item.count;
                best_reg  <= q_item.reach;
                k_reg     <= '0;
            end
            B_MUL: begin
                p_xc_reg <= ex * rd_entry_reg.cosine;
                p_ys_reg <= ey * rd_entry_reg.sine;
                p_xs_reg <= ex * rd_entry_reg.sine;
                p_yc_reg <= ey * rd_entry_reg.cosine;
                d_xc_reg <= rx_reg * rd_entry_reg.cosine;
                d_ys_reg <= ry_reg * rd_entry_reg.sine;
                d_xs_reg <= rx_reg * rd_entry_reg.sine;
                d_yc_reg <= ry_reg * rd_entry_reg.cosine;
                hw_reg   <= rd_entry_reg.half_w;
                hh_reg   <= rd_entry_reg.half_h;
            end
            B_SUM: begin
                ox_reg <= ox_full[LOC_W-1:0];
                oy_reg <= oy_full[LOC_W-1:0];
                dx_reg <= dx_full[DIR_W-1:0];
                dy_reg <= dy_full[DIR_W-1:0];
            end
            B_EVAL_X: begin
                tmin_reg <= tmin_x;
                tmax_reg <= tmax_x;
                miss_reg <= miss_x;
            end
            B_EVAL_Y: begin
                if (h_dist < best_reg) begin
                    best_reg <= h_dist;
                end
                k_reg <= k_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_dist_reg <= best_reg;
            m_hit_reg  <= (best_reg < reach_reg);
        end
    end

endmodule

`default_nettype wire

>>> design/rvob_checker.sv
// ----------------------------------------------------------------------------
// rvob_checker: port-level checks for ray_vs_oriented_boxes
// Watches reset, result holding, hit flag consistency and input backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module rvob_checker import rvob_pkg::*; (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [REACH_W-1:0] m_hit_distance,
    input wire logic               m_any_hit
);

    // no result right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_distance) && $stable(m_any_hit))
        else $error("stalled result changed");

    // a hit lies strictly below a 31-bit reach
    a_hit_below: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_any_hit |-> m_hit_distance != {REACH_W{1'b1}})
        else $error("hit at maximum distance");

    // backpressure rises only after an input transfer
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_ready))
        else $error("input ready dropped without a transfer");

endmodule

bind ray_vs_oriented_boxes rvob_checker u_rvob_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_hit_distance(m_hit_distance), .m_any_hit(m_any_hit)
);

`default_nettype wire
